// ----- rtl/glmf_pkg.sv -----
// Shared constants, types and state codes of the grid local maximum finder.
`timescale 1ns / 1ps

package glmf_pkg;

	// Grid limits and element width.
	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 32;
	localparam int VALUE_WIDTH = 32;

	// Index widths that follow from the limits.
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	// Fixed field widths of the ports.
	localparam int CFG_W       = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_W        = 32;
	localparam int PEAK_W      = 5;
	localparam int OUT_TDATA_W = 16;

	// Line store: three row slots.
	localparam int NUM_SLOTS = 3;
	localparam int SLOT_W    = 2;

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

	// Slot numbers.
	localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'd2;

	// One accepted element, already placed in the grid.
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic [SLOT_W-1:0]             slot;
		logic [ROW_W-1:0]              row;
		logic [COL_W-1:0]              col;
		logic                          has_up2;
		logic                          final_elem;
		logic [CFG_W-1:0]              cols;
	} job_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR,
		ST_MID,
		ST_UP,
		ST_DN,
		ST_LF,
		ST_RT,
		ST_CHK,
		ST_FIN
	} back_state_t;

endpackage

// ----- rtl/glmf_front.sv -----
// Front end: takes grid elements and configuration, tracks the grid position.
`timescale 1ns / 1ps

module glmf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [glmf_pkg::IN_W-1:0]       s_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [glmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [glmf_pkg::CFG_W-1:0]      cfg_data,
	output logic                            push,
	output glmf_pkg::job_t                  push_job,
	input  logic                            queue_full
);
	import glmf_pkg::*;

	logic [CFG_W-1:0]  num_rows_q;
	logic [CFG_W-1:0]  num_cols_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;

	logic [ROW_W:0]    rows_eff;
	logic [CFG_W-1:0]  cols_eff;
	logic [SLOT_W-1:0] cur_slot;
	logic              row_done;
	logic              col_done;
	logic              accept;
	logic              cfg_wr;

	assign s_tready  = !queue_full;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign push      = accept;

	// Register values out of range are used as the nearest legal size.
	always_comb begin
		if (num_rows_q == '0) begin
			rows_eff = (ROW_W+1)'(1);
		end else if (num_rows_q > CFG_W'(MAX_ROWS)) begin
			rows_eff = (ROW_W+1)'(MAX_ROWS);
		end else begin
			rows_eff = (ROW_W+1)'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			cols_eff = CFG_W'(1);
		end else if (num_cols_q > CFG_W'(MAX_COLS)) begin
			cols_eff = CFG_W'(MAX_COLS);
		end else begin
			cols_eff = num_cols_q;
		end
	end

	always_comb begin
		if (col_q != '0) begin
			cur_slot = slot_q;
		end else if (row_q == '0) begin
			cur_slot = SLOT_FIRST;
		end else if (slot_q == SLOT_LAST) begin
			cur_slot = SLOT_FIRST;
		end else begin
			cur_slot = slot_q + SLOT_W'(1);
		end
	end

	assign row_done = ({1'b0, row_q} + (ROW_W+1)'(1)) >= rows_eff;
	assign col_done = (CFG_W'(col_q) + CFG_W'(1)) >= cols_eff;

	always_comb begin
		push_job.value      = s_tdata[VALUE_WIDTH-1:0];
		push_job.slot       = cur_slot;
		push_job.row        = row_q;
		push_job.col        = col_q;
		push_job.has_up2    = row_q > ROW_W'(1);
		push_job.final_elem = row_done && col_done;
		push_job.cols       = cols_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CFG_W'(32);
			num_cols_q <= CFG_W'(32);
			row_q      <= '0;
			col_q      <= '0;
			slot_q     <= SLOT_FIRST;
		end else if (cfg_wr) begin
			// A register write abandons the grid in progress.
			if (cfg_index == REG_NUM_ROWS) begin
				num_rows_q <= cfg_data;
			end else begin
				num_cols_q <= cfg_data;
			end
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= SLOT_FIRST;
		end else if (accept) begin
			slot_q <= cur_slot;
			if (row_done && col_done) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_done) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// ----- rtl/glmf_queue.sv -----
// Short job queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module glmf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  glmf_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output glmf_pkg::job_t pop_job,
	output logic           not_empty
);
	import glmf_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- rtl/glmf_back.sv -----
// Back end: owns the line store, decides candidates and delivers results.
`timescale 1ns / 1ps

module glmf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  glmf_pkg::job_t               job,
	input  logic                         job_valid,
	output logic                         job_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [glmf_pkg::PEAK_W-1:0]  peak_row,
	output logic [glmf_pkg::PEAK_W-1:0]  peak_col,
	output logic                         last
);
	import glmf_pkg::*;

	logic signed [VALUE_WIDTH-1:0] row_mem [NUM_SLOTS][MAX_COLS];

	back_state_t state_q;
	back_state_t state_d;
	job_t        job_q;
	logic        flush_q;
	logic [COL_W-1:0] cand_col_q;

	logic signed [VALUE_WIDTH-1:0] rd_data_q;
	logic signed [VALUE_WIDTH-1:0] mid_q;
	logic mid_pend_q;
	logic nb_pend_q;
	logic fail_q;

	logic             hold_valid_q;
	logic [ROW_W-1:0] hold_row_q;
	logic [COL_W-1:0] hold_col_q;

	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_last_q;

	// Candidate geometry.
	logic [SLOT_W-1:0] prev_slot;
	logic [SLOT_W-1:0] prev2_slot;
	logic [SLOT_W-1:0] center_slot;
	logic [SLOT_W-1:0] up_slot;
	logic              up_ok;
	logic              down_ok;
	logic              left_ok;
	logic              right_ok;
	logic [ROW_W-1:0]  cand_row;
	logic              out_free;
	logic              pass;

	// Sequencer outputs.
	logic              rd_en;
	logic              rd_mid;
	logic              rd_nb;
	logic [SLOT_W-1:0] rd_slot;
	logic [COL_W-1:0]  rd_col;
	logic              wr_en;
	logic              stall;
	logic              out_load;
	logic              out_last_d;
	logic              hold_load;
	logic              set_cand;
	logic              flush_d;
	logic [COL_W-1:0]  cand_col_d;

	always_comb begin
		prev_slot   = (job_q.slot == SLOT_FIRST) ? SLOT_LAST : job_q.slot - SLOT_W'(1);
		prev2_slot  = (job_q.slot == SLOT_LAST) ? SLOT_FIRST : job_q.slot + SLOT_W'(1);
		center_slot = flush_q ? job_q.slot : prev_slot;
		up_slot     = flush_q ? prev_slot : prev2_slot;
		up_ok       = flush_q ? (job_q.row != '0) : job_q.has_up2;
		down_ok     = !flush_q;
		left_ok     = cand_col_q != '0;
		right_ok    = (CFG_W'(cand_col_q) + CFG_W'(1)) < job_q.cols;
		cand_row    = flush_q ? job_q.row : job_q.row - ROW_W'(1);
		out_free    = !out_valid_q || m_tready;
		pass        = !(fail_q || (nb_pend_q && (rd_data_q > mid_q)));
	end

	// Sequencer outputs.
	always_comb begin
		job_pop    = 1'b0;
		rd_en      = 1'b0;
		rd_mid     = 1'b0;
		rd_nb      = 1'b0;
		rd_slot    = center_slot;
		rd_col     = cand_col_q;
		wr_en      = 1'b0;
		stall      = 1'b0;
		out_load   = 1'b0;
		out_last_d = 1'b0;
		hold_load  = 1'b0;
		set_cand   = 1'b0;
		flush_d    = flush_q;
		cand_col_d = cand_col_q;
		case (state_q)
			ST_IDLE: begin
				job_pop = job_valid;
			end
			ST_WR: begin
				wr_en    = 1'b1;
				set_cand = 1'b1;
				if (job_q.row != '0) begin
					flush_d    = 1'b0;
					cand_col_d = job_q.col;
				end else begin
					flush_d    = 1'b1;
					cand_col_d = '0;
				end
			end
			ST_MID: begin
				rd_en  = 1'b1;
				rd_mid = 1'b1;
			end
			ST_UP: begin
				rd_en   = up_ok;
				rd_nb   = up_ok;
				rd_slot = up_slot;
			end
			ST_DN: begin
				rd_en   = down_ok;
				rd_nb   = down_ok;
				rd_slot = job_q.slot;
			end
			ST_LF: begin
				rd_en  = left_ok;
				rd_nb  = left_ok;
				rd_col = cand_col_q - COL_W'(1);
			end
			ST_RT: begin
				rd_en  = right_ok;
				rd_nb  = right_ok;
				rd_col = cand_col_q + COL_W'(1);
			end
			ST_CHK: begin
				// A new peak pushes the previous one out, which then cannot be last.
				stall     = pass && hold_valid_q && !out_free;
				out_load  = pass && hold_valid_q && out_free;
				hold_load = pass && !stall;
				set_cand  = !stall;
				if (!flush_q) begin
					flush_d    = 1'b1;
					cand_col_d = '0;
				end else begin
					cand_col_d = cand_col_q + COL_W'(1);
				end
			end
			ST_FIN: begin
				stall      = hold_valid_q && !out_free;
				out_load   = hold_valid_q && out_free;
				out_last_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = ST_WR;
				end
			end
			ST_WR: begin
				if (job_q.row != '0 || job_q.final_elem) begin
					state_d = ST_MID;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MID: state_d = ST_UP;
			ST_UP:  state_d = ST_DN;
			ST_DN:  state_d = ST_LF;
			ST_LF:  state_d = ST_RT;
			ST_RT:  state_d = ST_CHK;
			ST_CHK: begin
				if (stall) begin
					state_d = ST_CHK;
				end else if (!flush_q && job_q.final_elem) begin
					state_d = ST_MID;
				end else if (flush_q && right_ok) begin
					state_d = ST_MID;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Line store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[job_q.slot][job_q.col] <= job_q.value;
		end
		if (rd_en) begin
			rd_data_q <= row_mem[rd_slot][rd_col];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (mid_pend_q) begin
			mid_q <= rd_data_q;
		end
		if (hold_load) begin
			hold_row_q <= cand_row;
			hold_col_q <= cand_col_q;
		end
		if (out_load) begin
			out_row_q  <= hold_row_q;
			out_col_q  <= hold_col_q;
			out_last_q <= out_last_d;
		end
		if (set_cand) begin
			flush_q    <= flush_d;
			cand_col_q <= cand_col_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mid_pend_q   <= 1'b0;
			nb_pend_q    <= 1'b0;
			fail_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			mid_pend_q <= rd_mid;
			nb_pend_q  <= rd_nb;
			if (state_q == ST_MID) begin
				fail_q <= 1'b0;
			end else if (nb_pend_q && (rd_data_q > mid_q)) begin
				fail_q <= 1'b1;
			end
			if (hold_load) begin
				hold_valid_q <= 1'b1;
			end else if (state_q == ST_FIN && out_load) begin
				hold_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign peak_row = PEAK_W'(out_row_q);
	assign peak_col = PEAK_W'(out_col_q);
	assign last     = out_last_q;

endmodule

// ----- rtl/grid_local_maximum_finder_unit.sv -----
// Top level of the grid local maximum finder (four-neighbor peaks).
`timescale 1ns / 1ps

// The block takes the elements of a grid of signed values in raster order on
// the s_ stream and returns, on the m_ stream, the row and column of every
// element that is greater than or equal to each of its existing up, down,
// left and right neighbors, in raster order. Each word on m_ carries one peak;
// m_tlast marks the last peak caused by one input word. An input word that
// decides nothing produces no output word.
// Grid size comes from the configuration channel: index 0 is the row count,
// index 1 the column count (zero counts as one, large values saturate at 32).
// Writing either register starts a new grid. Write it only while idle.
// The front end accepts one word per cycle, while the queue is not full, into
// a two-entry job queue. The back end owns the three-row line store, which
// has a single read port, and reads every neighbor one per cycle: an element
// of the first row is only written, every other element is written and then
// decides the candidate above it, and the final element of a grid also decides
// each element of the last row while that row is flushed.
// Reset clears the grid position, the queue and the output register and sets
// both sizes to 32. When the receiver stalls, the result waits in the output
// register, the back end stops, the queue fills and s_tready drops.

module grid_local_maximum_finder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream, tdata: value[31:0].
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [glmf_pkg::IN_W-1:0]           s_tdata,
	// Result stream, tdata: peak_row[4:0], peak_col[9:5], zero padding[15:10].
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [glmf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [glmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [glmf_pkg::CFG_W-1:0]          cfg_data
);
	import glmf_pkg::*;

	job_t              push_job;
	job_t              pop_job;
	logic              push;
	logic              queue_full;
	logic              queue_not_empty;
	logic              job_pop;
	logic [PEAK_W-1:0] peak_row;
	logic [PEAK_W-1:0] peak_col;

	glmf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	glmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (job_pop),
		.pop_job   (pop_job),
		.not_empty (queue_not_empty)
	);

	glmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (pop_job),
		.job_valid (queue_not_empty),
		.job_pop   (job_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.peak_row  (peak_row),
		.peak_col  (peak_col),
		.last      (m_tlast)
	);

	// Pack the result word, first field in the low bits.
	assign m_tdata = {(OUT_TDATA_W - 2*PEAK_W)'(0), peak_col, peak_row};

endmodule

// ----- rtl/glmf_checker.sv -----
// Port-level checks of the grid local maximum finder, bound to the top level.
`timescale 1ns / 1ps

module glmf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [glmf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tlast
);
	import glmf_pkg::*;

	// A stalled result word keeps its contents.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// Padding above the peak fields is always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:2*PEAK_W] == '0)
		else $error("nonzero padding in result word");

	// Reset empties the output register.
	a_reset_clears: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result word present after reset");

endmodule

bind grid_local_maximum_finder_unit glmf_checker u_glmf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
